// File: sv/touch_packet_decoder_calibrated_defines.svh
// assertion macros for the touch packet decoder
`ifndef TOUCH_PACKET_DECODER_CALIBRATED_DEFINES_SVH
`define TOUCH_PACKET_DECODER_CALIBRATED_DEFINES_SVH

// condition in the same cycle implies consequence in the same cycle
`define TPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define TPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tpd_pkg.sv
// shared types and constants for the touch packet decoder
package tpd_pkg;

	// byte framing
	localparam logic [7:0] LEAD_BYTE  = 8'h55;
	localparam logic [7:0] TOUCH_MASK = 8'h03;
	localparam int         CNT_W      = 4;

	// positions of the bytes used from a packet
	localparam logic [CNT_W-1:0] POS_STATUS = 4'd2;
	localparam logic [CNT_W-1:0] POS_X_LO   = 4'd3;
	localparam logic [CNT_W-1:0] POS_X_HI   = 4'd4;
	localparam logic [CNT_W-1:0] POS_Y_LO   = 4'd5;
	localparam logic [CNT_W-1:0] POS_Y_HI   = 4'd6;

	// datapath widths
	localparam int SIZE_W  = 13;
	localparam int COORD_W = 16;
	localparam int SCALE_W = 17;
	localparam int MUL_W   = 18;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DIV_W   = 35;
	localparam int DCNT_W  = 6;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_SCREEN_WIDTH      = 3'd0,
		REG_SCREEN_HEIGHT     = 3'd1,
		REG_CAL_ENABLE        = 3'd2,
		REG_CAL_TOUCH_FIRST   = 3'd3,
		REG_CAL_SCREEN_FIRST  = 3'd4,
		REG_CAL_TOUCH_SECOND  = 3'd5,
		REG_CAL_SCREEN_SECOND = 3'd6
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_COLLECT,
		S_SCALE_X,
		S_SCALE_Y,
		S_SCALE_END,
		S_CAL_A,
		S_CAL_B,
		S_CAL_C,
		S_DIV,
		S_CAL_END,
		S_OUT
	} state_t;

endpackage

// File: sv/touch_packet_decoder_calibrated.sv
// touch packet decoder: framing, scaling, two-point calibration on one shared multiplier
// bytes are taken one per cycle while collecting; after the last byte of a packet that
// changes the touch state, both axes are scaled and, with calibration, two products
// and a 35-step restoring divide per axis are formed before the item is offered.
// input is not accepted during that work; a pending result does not stall collection.
// arst_n clears control state, config registers go to width=height=4096, others 0.
`include "touch_packet_decoder_calibrated_defines.svh"

module touch_packet_decoder_calibrated #(
	parameter int PACKET_BYTES = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_wr_en,
	input  logic [tpd_pkg::IDX_W-1:0]    cfg_index,
	input  logic [tpd_pkg::CFG_W-1:0]    cfg_wdata,
	// byte input
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // rx_byte [7:0]
	// result output
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [39:0]                  m_axis_tdata   // touched [0], pos_x [16:1],
	                                                    // pos_y [32:17], zero [39:33]
);
	import tpd_pkg::*;

	// configuration registers
	logic [SIZE_W-1:0] screen_width_q, screen_height_q;
	logic              cal_enable_q;
	logic [CFG_W-1:0]  cal_touch_first_q, cal_screen_first_q;
	logic [CFG_W-1:0]  cal_touch_second_q, cal_screen_second_q;

	// control state
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   byte_cnt_q;
	logic               last_touch_q;
	logic               sel_y_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic               out_valid_q;

	// payload registers
	logic [7:0]               status_q, x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic                     touch_q;
	logic [SCALE_W-1:0]       scaled_x_q, scaled_y_q;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic [DIV_W-1:0]         quo_q;
	logic [COORD_W-1:0]       rem_q, dvs_q;
	logic                     neg_q;
	logic [COORD_W-1:0]       res_x_q, res_y_q;
	logic                     out_touch_q;
	logic [COORD_W-1:0]       out_x_q, out_y_q;

	// decode
	logic                     in_fire, last_byte, pkt_touch, cal_on, out_load;
	logic [COORD_W-1:0]       t0, t1, s0, s1;
	logic [SCALE_W-1:0]       scaled_sel;
	logic signed [SCALE_W-1:0] den, sdiff;
	logic signed [MUL_W-1:0]  mul_a, mul_b, pos_off;
	logic signed [PROD_W-1:0] prod, num;
	logic [PROD_W-1:0]        num_mag;
	logic [SCALE_W-1:0]       den_mag;
	logic [COORD_W+1:0]       trial;
	logic [COORD_W:0]         shifted;
	logic [COORD_W-1:0]       quo_sat, scale_sat_y;

	// saturate a non-negative scaled value to the signed output range
	function automatic logic [COORD_W-1:0] sat_pos(input logic [SCALE_W-1:0] v);
		if (v > SCALE_W'(32767)) begin
			sat_pos = 16'h7fff;
		end else begin
			sat_pos = v[COORD_W-1:0];
		end
	endfunction

	// handshake terms
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign last_byte = (byte_cnt_q == CNT_W'(PACKET_BYTES - 1));
	assign pkt_touch = |(status_q & TOUCH_MASK);
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
	assign cal_on    = cal_enable_q
		&& (cal_touch_first_q[15:0] != cal_touch_second_q[15:0])
		&& (cal_touch_first_q[31:16] != cal_touch_second_q[31:16]);

	// per-axis calibration operands
	assign t0         = sel_y_q ? cal_touch_first_q[31:16]   : cal_touch_first_q[15:0];
	assign t1         = sel_y_q ? cal_touch_second_q[31:16]  : cal_touch_second_q[15:0];
	assign s0         = sel_y_q ? cal_screen_first_q[31:16]  : cal_screen_first_q[15:0];
	assign s1         = sel_y_q ? cal_screen_second_q[31:16] : cal_screen_second_q[15:0];
	assign scaled_sel = sel_y_q ? scaled_y_q : scaled_x_q;
	assign den        = $signed({1'b0, t1}) - $signed({1'b0, t0});
	assign sdiff      = $signed({1'b0, s1}) - $signed({1'b0, s0});
	assign pos_off    = $signed({1'b0, scaled_sel}) - $signed({2'b00, t0});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_COLLECT: begin
				if (in_fire && last_byte && (pkt_touch != last_touch_q)) begin
					state_d = S_SCALE_X;
				end
			end
			S_SCALE_X:   state_d = S_SCALE_Y;
			S_SCALE_Y:   state_d = S_SCALE_END;
			S_SCALE_END: state_d = cal_on ? S_CAL_A : S_OUT;
			S_CAL_A:     state_d = S_CAL_B;
			S_CAL_B:     state_d = S_CAL_C;
			S_CAL_C:     state_d = S_DIV;
			S_DIV: begin
				if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
					state_d = S_CAL_END;
				end
			end
			S_CAL_END:   state_d = sel_y_q ? S_OUT : S_CAL_A;
			S_OUT: begin
				if (out_load) begin
					state_d = S_COLLECT;
				end
			end
			default:     state_d = S_COLLECT;
		endcase
	end

	// outputs of the sequencer: ready and shared multiplier operands
	always_comb begin
		s_axis_tready = (state_q == S_COLLECT);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SCALE_X: begin
				mul_a = $signed({2'b00, x_hi_q, x_lo_q});
				mul_b = $signed({5'b0, screen_width_q});
			end
			S_SCALE_Y: begin
				mul_a = $signed({2'b00, y_hi_q, y_lo_q});
				mul_b = $signed({5'b0, screen_height_q});
			end
			S_CAL_A: begin
				mul_a = $signed({2'b00, s0});
				mul_b = MUL_W'(den);
			end
			S_CAL_B: begin
				mul_a = MUL_W'(sdiff);
				mul_b = pos_off;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared multiplier
	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// numerator, magnitudes and one restoring divide step
	assign num     = acc_q + prod_q;
	assign num_mag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
	assign den_mag = den[SCALE_W-1] ? SCALE_W'(-den) : SCALE_W'(den);
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	// signed saturation of the quotient
	always_comb begin
		if (neg_q) begin
			if (quo_q > DIV_W'(32768)) begin
				quo_sat = 16'h8000;
			end else begin
				quo_sat = 16'(16'd0 - quo_q[COORD_W-1:0]);
			end
		end else begin
			if (quo_q > DIV_W'(32767)) begin
				quo_sat = 16'h7fff;
			end else begin
				quo_sat = quo_q[COORD_W-1:0];
			end
		end
	end

	assign scale_sat_y = sat_pos(prod_q[SCALE_W+11:12]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q      <= 13'd4096;
			screen_height_q     <= 13'd4096;
			cal_enable_q        <= 1'b0;
			cal_touch_first_q   <= '0;
			cal_screen_first_q  <= '0;
			cal_touch_second_q  <= '0;
			cal_screen_second_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCREEN_WIDTH:      screen_width_q      <= cfg_wdata[SIZE_W-1:0];
				REG_SCREEN_HEIGHT:     screen_height_q     <= cfg_wdata[SIZE_W-1:0];
				REG_CAL_ENABLE:        cal_enable_q        <= cfg_wdata[0];
				REG_CAL_TOUCH_FIRST:   cal_touch_first_q   <= cfg_wdata;
				REG_CAL_SCREEN_FIRST:  cal_screen_first_q  <= cfg_wdata;
				REG_CAL_TOUCH_SECOND:  cal_touch_second_q  <= cfg_wdata;
				REG_CAL_SCREEN_SECOND: cal_screen_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_COLLECT;
			byte_cnt_q   <= '0;
			last_touch_q <= 1'b0;
			sel_y_q      <= 1'b0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// packet framing
			if (in_fire) begin
				if (byte_cnt_q == '0 && s_axis_tdata != LEAD_BYTE) begin
					byte_cnt_q <= '0;
				end else if (last_byte) begin
					byte_cnt_q <= '0;
					if (pkt_touch != last_touch_q) begin
						last_touch_q <= pkt_touch;
					end
				end else begin
					byte_cnt_q <= byte_cnt_q + 1'b1;
				end
			end
			// axis select and divide step count
			if (state_q == S_SCALE_END) begin
				sel_y_q <= 1'b0;
			end else if (state_q == S_CAL_END) begin
				sel_y_q <= 1'b1;
			end
			if (state_q == S_CAL_C) begin
				div_cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			// output register occupancy
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		// keep only the bytes used from a packet
		if (in_fire) begin
			if (byte_cnt_q == POS_STATUS) status_q <= s_axis_tdata;
			if (byte_cnt_q == POS_X_LO)   x_lo_q   <= s_axis_tdata;
			if (byte_cnt_q == POS_X_HI)   x_hi_q   <= s_axis_tdata;
			if (byte_cnt_q == POS_Y_LO)   y_lo_q   <= s_axis_tdata;
			if (byte_cnt_q == POS_Y_HI)   y_hi_q   <= s_axis_tdata;
			if (last_byte)                touch_q  <= pkt_touch;
		end
		prod_q <= prod;
		unique case (state_q)
			S_SCALE_Y: scaled_x_q <= prod_q[SCALE_W+11:12];
			S_SCALE_END: begin
				scaled_y_q <= prod_q[SCALE_W+11:12];
				res_x_q    <= sat_pos(scaled_x_q);
				res_y_q    <= scale_sat_y;
			end
			S_CAL_B: acc_q <= prod_q;
			S_CAL_C: begin
				neg_q <= num[PROD_W-1] ^ den[SCALE_W-1];
				quo_q <= num_mag[DIV_W-1:0];
				rem_q <= '0;
				dvs_q <= den_mag[COORD_W-1:0];
			end
			S_DIV: begin
				if (!trial[COORD_W+1]) begin
					rem_q <= trial[COORD_W-1:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[COORD_W-1:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
			end
			S_CAL_END: begin
				if (sel_y_q) begin
					res_y_q <= quo_sat;
				end else begin
					res_x_q <= quo_sat;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_touch_q <= touch_q;
			out_x_q     <= res_x_q;
			out_y_q     <= res_y_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_y_q, out_x_q, out_touch_q};

	// checks
	`TPD_ASSERT_SAME(a_cnt_range, clk, arst_n, 1'b1, byte_cnt_q < CNT_W'(PACKET_BYTES), "byte count past packet end")
	`TPD_ASSERT_SAME(a_div_nonzero, clk, arst_n, state_q == S_DIV, dvs_q != '0 && div_cnt_q < DCNT_W'(DIV_W), "bad divide step")
	`TPD_ASSERT_NEXT(a_out_wait, clk, arst_n, state_q == S_OUT && out_valid_q && !m_axis_tready, state_q == S_OUT && out_valid_q, "result dropped while output busy")

endmodule

// File: tb/sv/touch_packet_decoder_calibrated_tb.sv
`timescale 1ns / 100ps
// testbench for the touch packet decoder: byte streams checked against a built-in packet predictor
module touch_packet_decoder_calibrated_tb;
	import tpd_pkg::*;

	localparam int PKT_LEN = 10;
	localparam int SETTLE_CYCLES = 120;
	localparam int DRAIN_LIMIT = 20000;
	localparam int RANDOM_BYTES = 320;
	localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

	// one decoded touch report
	typedef struct packed {
		logic        touched;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} touch_report_t;

	typedef enum logic [1:0] {
		SINK_STEADY,
		SINK_COIN,
		SINK_BURSTY
	} sink_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;   // rx_byte [7:0]
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [39:0]        m_axis_tdata;        // touched [0], pos_x [16:1], pos_y [32:17]

	// predictor copy of the configuration
	logic [SIZE_W-1:0]  scr_w = 13'd4096;
	logic [SIZE_W-1:0]  scr_h = 13'd4096;
	logic               cal_on = 1'b0;
	logic [31:0]        tpt_a = '0;
	logic [31:0]        spt_a = '0;
	logic [31:0]        tpt_b = '0;
	logic [31:0]        spt_b = '0;

	// predictor copy of the framing state
	logic [7:0]         frame_bytes [PKT_LEN];
	int                 frame_fill = 0;
	logic               touch_state = 1'b0;

	touch_report_t      touch_reports [$];
	int                 fault_count = 0;
	int                 bytes_sent = 0;
	int                 burst_left = 0;
	sink_mode_t         sink_mode = SINK_STEADY;
	int                 sink_hold = 0;
	int                 sink_cycle = 0;

	touch_packet_decoder_calibrated #(
		.PACKET_BYTES(PKT_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	// saturate to the signed 16-bit output range
	function automatic logic [15:0] sat16(input longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	// two-point line through (t0,s0) and (t1,s1), truncated toward zero
	function automatic longint cal_axis(input longint v, input longint t0, input longint s0,
		input longint t1, input longint s1);
		longint den;
		den = t1 - t0;
		return (s0 * den + (s1 - s0) * (v - t0)) / den;
	endfunction

	// framing, scaling and calibration of one accepted byte
	function automatic void decode_rx_byte(input logic [7:0] b);
		logic          new_touch;
		longint        raw_x;
		longint        raw_y;
		longint        px;
		longint        py;
		touch_report_t rep;
		if (frame_fill == 0 && b != LEAD_BYTE)
			return;
		frame_bytes[frame_fill] = b;
		frame_fill++;
		if (frame_fill < PKT_LEN)
			return;
		frame_fill = 0;
		new_touch = (frame_bytes[POS_STATUS] & TOUCH_MASK) != 8'h00;
		if (new_touch == touch_state)
			return;
		raw_x = {frame_bytes[POS_X_HI], frame_bytes[POS_X_LO]};
		raw_y = {frame_bytes[POS_Y_HI], frame_bytes[POS_Y_LO]};
		px = raw_x * longint'(scr_w) / 4096;
		py = raw_y * longint'(scr_h) / 4096;
		if (cal_on && tpt_b[15:0] != tpt_a[15:0] && tpt_b[31:16] != tpt_a[31:16]) begin
			px = cal_axis(px, tpt_a[15:0], spt_a[15:0], tpt_b[15:0], spt_b[15:0]);
			py = cal_axis(py, tpt_a[31:16], spt_a[31:16], tpt_b[31:16], spt_b[31:16]);
		end
		touch_state = new_touch;
		rep.touched = new_touch;
		rep.pos_x = sat16(px);
		rep.pos_y = sat16(py);
		touch_reports.push_back(rep);
	endfunction

	// send one byte, with random gaps between bursts
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		decode_rx_byte(b);
		burst_left--;
		bytes_sent++;
	endtask

	// lead, filler, status, x and y little-endian, filler to the packet end
	task automatic send_packet(input logic [7:0] status, input logic [15:0] x,
		input logic [15:0] y, input logic [7:0] fill);
		send_byte(LEAD_BYTE);
		send_byte(fill);
		send_byte(status);
		send_byte(x[7:0]);
		send_byte(x[15:8]);
		send_byte(y[7:0]);
		send_byte(y[15:8]);
		repeat (PKT_LEN - 7) send_byte(fill);
	endtask

	// finish any open packet, wait for all reports, then let the datapath go quiet
	task automatic settle_block();
		int waited;
		while (frame_fill != 0)
			send_byte(8'h00);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		waited = 0;
		while (touch_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (touch_reports.size() != 0) begin
			$display("%0t ns: %0d touch reports expected but never seen", $time,
				touch_reports.size());
			fault_count++;
			touch_reports.delete();
		end
	endtask

	// register write, mirrored into the predictor
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			REG_SCREEN_WIDTH: begin
				scr_w = val[SIZE_W-1:0];
			end
			REG_SCREEN_HEIGHT: begin
				scr_h = val[SIZE_W-1:0];
			end
			REG_CAL_ENABLE: begin
				cal_on = val[0];
			end
			REG_CAL_TOUCH_FIRST: begin
				tpt_a = val;
			end
			REG_CAL_SCREEN_FIRST: begin
				spt_a = val;
			end
			REG_CAL_TOUCH_SECOND: begin
				tpt_b = val;
			end
			REG_CAL_SCREEN_SECOND: begin
				spt_b = val;
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
	endtask

	// points hold x in the low half and y in the high half
	task automatic set_calibration(input logic en, input logic [31:0] ta, input logic [31:0] sa,
		input logic [31:0] tb, input logic [31:0] sb);
		write_reg(REG_CAL_ENABLE, {31'd0, en});
		write_reg(REG_CAL_TOUCH_FIRST, ta);
		write_reg(REG_CAL_SCREEN_FIRST, sa);
		write_reg(REG_CAL_TOUCH_SECOND, tb);
		write_reg(REG_CAL_SCREEN_SECOND, sb);
	endtask

	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd4096;
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	// mostly points inside the 12-bit touch range, sometimes anything
	function automatic logic [31:0] pick_point();
		logic [31:0] p;
		if ($urandom_range(0, 9) < 7)
			p = {16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095))};
		else
			p = $urandom;
		return p;
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'h0FFF;
					default: return 16'h8000;
				endcase
			end
			default: return 16'($urandom_range(0, 4095));
		endcase
	endfunction

	// result receiver with a stall pattern that changes now and then
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready = 1'b0;
		end else if (sink_mode == SINK_BURSTY && $urandom_range(0, 7) == 0) begin
			sink_hold = $urandom_range(0, 23);
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = (sink_mode != SINK_COIN) || ($urandom_range(0, 1) == 1);
		end
		sink_cycle++;
		if (sink_cycle % 200 == 0)
			sink_mode = sink_mode_t'($urandom_range(0, 2));
	end

	// compare every accepted item with the oldest predicted report
	always @(posedge clk) begin
		touch_report_t want;
		touch_report_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.touched = m_axis_tdata[0];
			got.pos_x = m_axis_tdata[16:1];
			got.pos_y = m_axis_tdata[32:17];
			if (touch_reports.size() == 0) begin
				$display("%0t ns: item with no report pending, touched %0d x %0d y %0d",
					$time, got.touched, $signed(got.pos_x), $signed(got.pos_y));
				fault_count++;
			end else begin
				want = touch_reports.pop_front();
				if (got.touched !== want.touched) begin
					$display("%0t ns: touched expected %0d got %0d", $time,
						want.touched, got.touched);
					fault_count++;
				end
				if (got.pos_x !== want.pos_x) begin
					$display("%0t ns: pos_x expected %0d got %0d", $time,
						$signed(want.pos_x), $signed(got.pos_x));
					fault_count++;
				end
				if (got.pos_y !== want.pos_y) begin
					$display("%0t ns: pos_y expected %0d got %0d", $time,
						$signed(want.pos_y), $signed(got.pos_y));
					fault_count++;
				end
			end
		end
	end

	// noise before the lead, lead inside a packet, saturation, repeated touch state
	task automatic test_framing();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_packet(8'h01, 16'hFFFF, 16'h0000, LEAD_BYTE);
		send_packet(8'h02, 16'h1234, 16'h5678, 8'hAA);
		send_packet(8'hFC, 16'h0FFF, 16'hFFFF, 8'h00);
	endtask

	// zero and unit screen sizes, then half height
	task automatic test_scaling();
		settle_block();
		set_screen(32'd0, 32'd1);
		send_packet(8'h03, 16'hFFFF, 16'hFFFF, 8'h55);
		settle_block();
		set_screen(32'd4096, 32'd2048);
		send_packet(8'h00, 16'h8000, 16'hFFFF, 8'h7E);
	endtask

	// bypass on equal x or equal y touch points, then a steep line that saturates both ways
	task automatic test_calibration();
		settle_block();
		set_screen(32'd4096, 32'd4096);
		set_calibration(1'b1, {16'd100, 16'd100}, {16'd10, 16'd10},
			{16'd3900, 16'd100}, {16'd470, 16'd790});
		send_packet(8'h02, 16'd2000, 16'd1000, 8'h11);
		settle_block();
		write_reg(REG_CAL_TOUCH_SECOND, {16'd100, 16'd3900});
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		send_packet(8'h00, 16'd300, 16'd3000, 8'h22);
		settle_block();
		set_calibration(1'b1, {16'd100, 16'd100}, 32'h0000_0000,
			{16'd101, 16'd101}, 32'hFFFF_FFFF);
		send_packet(8'h01, 16'h0000, 16'hFFFF, 8'h33);
	endtask

	// random well-formed packets mixed with stray bytes, under changing configurations
	task automatic test_random_traffic();
		int          bytes_floor;
		int          phase_end;
		logic        want_touch;
		logic [7:0]  status;
		logic [31:0] ta;
		logic [31:0] tb;
		bytes_floor = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < bytes_floor) begin
			settle_block();
			set_screen(pick_size(), pick_size());
			ta = pick_point();
			tb = pick_point();
			case ($urandom_range(0, 5))
				0: tb[15:0] = ta[15:0];
				1: tb[31:16] = ta[31:16];
				default: begin
				end
			endcase
			set_calibration($urandom_range(0, 2) != 0, ta, pick_point(), tb, pick_point());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNMAPPED, $urandom);
			phase_end = bytes_sent + $urandom_range(60, 140);
			if (phase_end > bytes_floor)
				phase_end = bytes_floor;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(0, 99) < 15) begin
					repeat ($urandom_range(1, 5))
						send_byte(($urandom_range(0, 3) == 0) ? LEAD_BYTE : 8'($urandom));
				end else begin
					want_touch = ($urandom_range(0, 3) != 0) ? !touch_state : touch_state;
					status = 8'($urandom) & ~TOUCH_MASK;
					if (want_touch)
						status = status | 8'($urandom_range(1, 3));
					send_packet(status, pick_coord(), pick_coord(),
						($urandom_range(0, 3) == 0) ? LEAD_BYTE : 8'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_framing();
		test_scaling();
		test_calibration();
		test_random_traffic();
		settle_block();
		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/tpd_pkg.sv
sv/touch_packet_decoder_calibrated.sv
tb/sv/touch_packet_decoder_calibrated_tb.sv
